/* rtl/dsss_pkg.sv */
// Shared types and constants for the decimal seven-segment scanner.
// No dependencies; the scan, digit, queue and top-level rtl files import this package.
package dsss_pkg;

  // Powers of ten used for digit counting and digit selection.
  localparam logic [31:0] POW10 [8] = '{
    32'd1, 32'd10, 32'd100, 32'd1000,
    32'd10000, 32'd100000, 32'd1000000, 32'd10000000
  };

  localparam logic [7:0] SLOT_TICKS_RESET = 8'd5;

  // Per-word tag that travels beside the quotient.
  typedef struct packed {
    logic [3:0] digit_enable;
    logic       pass_start;
  } dsss_tag_t;

  // One finished output word.
  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments_n;
    logic [3:0] digit_value;
    logic       pass_start;
  } dsss_result_t;

  // Active-low segments, bit0 = a .. bit6 = g; nine has no d segment.
  function automatic logic [6:0] seg_decode(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h18;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

/* rtl/dsss_scan.sv */
// Scan sequencer: pass/slot/position state, digit count and quotient by 10^shift.
// Depends on dsss_pkg.
module dsss_scan import dsss_pkg::*; #(
  parameter int DIGIT_LINES = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [11:0]            sample,
  input  logic [7:0]             slot_ticks,
  output logic                   q_valid,
  output logic [SAMPLE_BITS-1:0] quot,
  output dsss_tag_t              tag
);

  localparam int POS_W  = (DIGIT_LINES > 1) ? $clog2(DIGIT_LINES) : 1;
  localparam int CNT_W  = $clog2(DIGIT_LINES + 1);
  localparam int MUL_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * SAMPLE_BITS + 1;

  // Reciprocal constants: v / 10^k == (v * Mul) >> Sh for every v below 2^SAMPLE_BITS.
  logic [MUL_W-1:0] mul_tab [8];
  logic [5:0]       sh_tab  [8];

  for (genvar k = 0; k < 8; k++) begin : g_recip
    localparam longint unsigned Div = 64'(POW10[k]);
    localparam int              Lg  = $clog2(Div);
    localparam int              Sh  = SAMPLE_BITS + Lg;
    localparam longint unsigned Mul = ((64'd1 << Sh) + Div - 64'd1) / Div;
    assign mul_tab[k] = MUL_W'(Mul);
    assign sh_tab[k]  = 6'(Sh);
  end

  logic [SAMPLE_BITS-1:0] shown_value;
  logic [CNT_W-1:0]       digit_count;
  logic [POS_W-1:0]       position;
  logic [7:0]             slot_counter;

  logic [SAMPLE_BITS-1:0] shown_value_next;
  logic [CNT_W-1:0]       digit_count_next;
  logic [POS_W-1:0]       position_next;
  logic [7:0]             slot_counter_next;

  logic                   pos_bad;
  logic [POS_W-1:0]       pos_cur;
  logic [7:0]             cnt_cur;
  logic                   start;
  logic [3:0]             total;
  logic [3:0]             total_cap;
  logic [3:0]             shift_raw;
  logic [2:0]             shift;
  logic [PROD_W-1:0]      prod;
  logic [7:0]             ticks;
  logic [7:0]             cnt_inc;
  logic                   slot_end;
  logic [CNT_W-1:0]       pos_inc;
  logic [7:0]             line;

  always_comb begin
    pos_bad = (digit_count == '0) || (digit_count > CNT_W'(DIGIT_LINES)) ||
              (CNT_W'(position) >= digit_count);
    pos_cur = pos_bad ? '0 : position;
    cnt_cur = pos_bad ? 8'd0 : slot_counter;
    start   = (pos_cur == '0) && (cnt_cur == 8'd0);

    shown_value_next = start ? SAMPLE_BITS'(sample) : shown_value;

    // full decimal length of the shown value
    total = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if (32'(shown_value_next) >= POW10[k]) total = total + 4'd1;
    end
    total_cap = (total > 4'(DIGIT_LINES)) ? 4'(DIGIT_LINES) : total;
    digit_count_next = start ? CNT_W'(total_cap) : digit_count;

    // most significant digits first, left-justified
    shift_raw = total - 4'd1 - 4'(pos_cur);
    shift     = (shift_raw > 4'd7) ? 3'd0 : shift_raw[2:0];
    prod      = PROD_W'(shown_value_next) * PROD_W'(mul_tab[shift]);

    // slot timing; zero ticks behaves as one
    ticks    = (slot_ticks == 8'd0) ? 8'd1 : slot_ticks;
    cnt_inc  = cnt_cur + 8'd1;
    slot_end = (cnt_inc >= ticks) || (cnt_inc == 8'd0);
    pos_inc  = CNT_W'(pos_cur) + CNT_W'(1);
    if (slot_end) begin
      slot_counter_next = 8'd0;
      position_next     = (pos_inc >= digit_count_next) ? '0 : POS_W'(pos_inc);
    end else begin
      slot_counter_next = cnt_inc;
      position_next     = pos_cur;
    end

    line = 8'd1 << pos_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_value  <= '0;
      digit_count  <= CNT_W'(1);
      position     <= '0;
      slot_counter <= 8'd0;
      q_valid      <= 1'b0;
    end else if (en) begin
      q_valid <= in_valid;
      if (in_valid) begin
        shown_value  <= shown_value_next;
        digit_count  <= digit_count_next;
        position     <= position_next;
        slot_counter <= slot_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      quot             <= SAMPLE_BITS'(prod >> sh_tab[shift]);
      tag.digit_enable <= line[3:0];
      tag.pass_start   <= start;
    end
  end

endmodule

/* rtl/dsss_digit.sv */
// Digit stage: quotient mod 10 by reciprocal multiply, then segment decode.
// Depends on dsss_pkg.
module dsss_digit import dsss_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0] quot,
  input  dsss_tag_t              tag,
  output dsss_result_t           result
);

  localparam int              PROD_W = 2 * SAMPLE_BITS + 1;
  localparam int              Sh10   = SAMPLE_BITS + 4;
  localparam longint unsigned Mul10  = ((64'd1 << Sh10) + 64'd9) / 64'd10;

  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] q10;
  logic [SAMPLE_BITS-1:0] q10_x10;
  logic [3:0]             dv;

  always_comb begin
    prod    = PROD_W'(quot) * PROD_W'(Mul10);
    q10     = SAMPLE_BITS'(prod >> Sh10);
    q10_x10 = (q10 << 3) + (q10 << 1);
    dv      = 4'(quot - q10_x10);

    result.digit_enable = tag.digit_enable;
    result.segments_n   = seg_decode(dv);
    result.digit_value  = dv;
    result.pass_start   = tag.pass_start;
  end

endmodule

/* rtl/dsss_out_queue.sv */
// Two-word output queue; decouples the result side from the pipeline.
// Depends on dsss_pkg.
module dsss_out_queue import dsss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dsss_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output dsss_result_t pop_data
);

  dsss_result_t mem [2];
  logic [1:0]   count;
  logic         wr_ptr;
  logic         rd_ptr;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/decimal_seven_segment_scanner_core.sv */
// Top level of the multiplexed seven-segment decimal scanner.
// Depends on dsss_pkg, dsss_scan, dsss_digit, dsss_out_queue.
//
//  channel | signals                                        | dir | word
//  --------+------------------------------------------------+-----+---------------------
//  in      | in_valid, in_ready, sample                     | in  | one tick, one sample
//  out     | out_valid, out_ready, digit_enable, segments_n,| out | one lit digit
//          | digit_value, pass_start                        |     |
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | in  | slot_ticks
//
// One input word per cycle while the queue is not full; each word passes the input
// register and the quotient register before its output word is written into the queue.
// Throughput is one word per cycle unless the queue is full; the next scan state is combinational.
// Reset (synchronous rst) clears the scan state to position 0, slot count 0, one digit,
// and slot_ticks to 5; the queue empties.
// A stalled output fills the two-word queue, then in_ready drops; in_ready depends only
// on queue fill, never combinationally on out_ready.
module decimal_seven_segment_scanner_core import dsss_pkg::*; #(
  parameter int DIGIT_LINES = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  digit_enable,
  output logic [6:0]  segments_n,
  output logic [3:0]  digit_value,
  output logic        pass_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                   en;         // whole pipeline advances
  logic                   q_full;
  logic                   s1_valid;   // input register
  logic [11:0]            s1_sample;
  logic [7:0]             slot_ticks;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] quot;
  dsss_tag_t              tag;
  dsss_result_t           result;
  dsss_result_t           head;

  assign en        = !q_full;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // config register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= SLOT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) s1_sample <= sample;
  end

  // scan state, digit count, and sample / 10^shift
  dsss_scan #(
    .DIGIT_LINES (DIGIT_LINES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s1_valid),
    .sample     (s1_sample),
    .slot_ticks (slot_ticks),
    .q_valid    (q_valid),
    .quot       (quot),
    .tag        (tag)
  );

  // mod 10 and segment decode
  dsss_digit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_digit (
    .quot   (quot),
    .tag    (tag),
    .result (result)
  );

  dsss_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (en && q_valid),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_data  (head)
  );

  assign digit_enable = head.digit_enable;
  assign segments_n   = head.segments_n;
  assign digit_value  = head.digit_value;
  assign pass_start   = head.pass_start;

endmodule

/* rtl/dsss_checker.sv */
// Port-level checker for the scanner core, attached by bind.
// Depends only on the top-level port list.
module dsss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [11:0] sample,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  digit_enable,
  input logic [6:0]  segments_n,
  input logic [3:0]  digit_value,
  input logic        pass_start,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_data
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // decimal digit only
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_value <= 4'd9))
    else $error("digit_value out of range");

  // a new pass always starts on the leftmost line
  a_pass_leftmost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pass_start) |-> (digit_enable == 4'b0001))
    else $error("pass_start away from first digit line");

  // segments follow the digit: eight lights everything, one lights b and c
  a_seg_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_value != 4'd8 || segments_n == 7'h00) &&
                   (digit_value != 4'd1 || segments_n == 7'h79)))
    else $error("segments do not match digit");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(digit_enable) && $stable(segments_n) &&
       $stable(digit_value) && $stable(pass_start)))
    else $error("output word changed while stalled");

endmodule

bind decimal_seven_segment_scanner_core dsss_checker u_dsss_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for decimal_seven_segment_scanner_core.
// Needs only the RTL (dsss_pkg and the core); an in-bench scan model predicts
// each output word from the accepted input words and the slot_ticks setting.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsss_pkg::SLOT_TICKS_RESET;

  localparam int unsigned DISPLAY_LINES = 4;
  localparam int unsigned WORD_GOAL     = 1750;      // input words to send in all
  localparam int unsigned SETTLE_CYCLES = 8;         // more than the pipeline depth
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned PRINT_CAP     = 30;

  // Active-low segment patterns, bit0 = a .. bit6 = g; nine is drawn without d.
  localparam logic [6:0] SEG_N [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
  };

  // Values on the digit-count boundaries, the 12-bit extremes and 2048.
  localparam logic [11:0] BOUNDARY_VALUES [10] = '{
    12'd0, 12'd1, 12'd9, 12'd10, 12'd99, 12'd100, 12'd999, 12'd1000, 12'd2048, 12'd4095
  };

  // Scanner state as the block keeps it, at the block's widths.
  typedef struct packed {
    logic [7:0]  slot_ticks;
    logic [11:0] shown_value;
    logic [2:0]  digit_count;
    logic [1:0]  position;
    logic [7:0]  slot_counter;
  } scan_state_t;

  // One lit digit: what the output channel carries per word.
  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments_n;
    logic [3:0] digit_value;
    logic       pass_start;
  } lit_digit_t;

  // Port-side signals; every input is known from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  digit_enable;
  logic [6:0]  segments_n;
  logic [3:0]  digit_value;
  logic        pass_start;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Two copies of the scan model: one runs ahead while words are queued,
  // so the generator knows which word opens a pass; the other follows the
  // words actually accepted and yields the expected digits.
  scan_state_t lookahead_state;
  scan_state_t tracked_state;

  logic [11:0] sample_queue [$];     // words waiting for the driver
  lit_digit_t  digit_queue [$];      // expected output words, oldest first
  logic [11:0] held_sample;          // word currently on the input channel
  bit          in_busy = 1'b0;       // held_sample not yet accepted
  bit          in_calm = 1'b0;       // stretch with no input gaps
  bit          out_calm = 1'b0;      // stretch with no output stalls
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_queued = 0;
  int unsigned passes_queued = 0;
  int unsigned words_checked = 0;
  int unsigned slot_writes = 0;

  decimal_seven_segment_scanner_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_enable (digit_enable),
    .segments_n   (segments_n),
    .digit_value  (digit_value),
    .pass_start   (pass_start),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Synchronous reset, released on a falling edge.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic scan_state_t reset_state();
    scan_state_t st;
    st.slot_ticks   = SLOT_TICKS_RESET;
    st.shown_value  = '0;
    st.digit_count  = 3'd1;
    st.position     = '0;
    st.slot_counter = '0;
    return st;
  endfunction

  // Decimal digits in v, no cap.
  function automatic int unsigned decimal_width(input logic [11:0] v);
    int unsigned n;
    int unsigned bound;
    n = 1;
    bound = 10;
    while (v >= bound) begin
      n++;
      bound *= 10;
    end
    return n;
  endfunction

  // One scan tick: consume a sample word, advance st, return the lit digit.
  function automatic lit_digit_t scan_tick(inout scan_state_t st, input logic [11:0] smp);
    lit_digit_t  w;
    int unsigned total;
    int unsigned shift;
    int unsigned scale;
    int unsigned ticks;
    w.pass_start = 1'b0;
    // A corrupt digit count or a position past it restarts the pass.
    if (st.digit_count < 1 || st.digit_count > DISPLAY_LINES ||
        st.position >= st.digit_count) begin
      st.position = '0;
      st.slot_counter = '0;
    end
    // First tick of a pass latches the sample; all other samples are dropped.
    if (st.position == 0 && st.slot_counter == 0) begin
      st.shown_value = smp;
      w.pass_start = 1'b1;
      total = decimal_width(smp);
      st.digit_count = 3'(total > DISPLAY_LINES ? DISPLAY_LINES : total);
    end
    // Left-justified: the first line shows the most significant digit.
    total = decimal_width(st.shown_value);
    shift = total - 1 - st.position;
    scale = 1;
    repeat (shift) scale *= 10;
    w.digit_value  = 4'((st.shown_value / scale) % 10);
    w.digit_enable = 4'(1 << st.position);
    w.segments_n   = SEG_N[w.digit_value];
    // A slot length of zero behaves as one; a slot also ends when the
    // counter is already past a freshly lowered slot_ticks.
    ticks = (st.slot_ticks == 0) ? 1 : st.slot_ticks;
    st.slot_counter = st.slot_counter + 8'd1;
    if (st.slot_counter >= ticks || st.slot_counter == 0) begin
      st.slot_counter = '0;
      st.position = st.position + 2'd1;
      if (st.position >= st.digit_count) st.position = '0;
    end
    return w;
  endfunction

  // Gap length: mostly none or short, now and then long; none while calm.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Queue one tick word and run it through the look-ahead model.
  task automatic push_tick(input logic [11:0] smp);
    lit_digit_t w;
    w = scan_tick(lookahead_state, smp);
    sample_queue.push_back(smp);
    words_queued++;
    if (w.pass_start) passes_queued++;
  endtask

  // Fill the rest of the current pass with random words (the block drops
  // them), then open a new pass with smp.
  task automatic open_pass(input logic [11:0] smp);
    scan_state_t probe;
    lit_digit_t  w;
    forever begin
      probe = lookahead_state;
      w = scan_tick(probe, 12'd0);
      if (w.pass_start) break;
      push_tick(12'($urandom));
    end
    push_tick(smp);
  endtask

  // Random words that leave the scan somewhere mid-slot or mid-pass.
  task automatic add_filler(input int unsigned n);
    repeat (n) push_tick(12'($urandom));
  endtask

  // slot_ticks is written only with the pipeline empty; both model copies
  // pick up the new value at the accepting edge.
  task automatic set_slot_ticks(input logic [7:0] v);
    while (sample_queue.size() != 0 || in_busy || digit_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lookahead_state.slot_ticks = v;
    tracked_state.slot_ticks   = v;
    slot_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: holds each word until accepted, random gaps between words.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        held_sample = sample_queue.pop_front();
        sample   <= held_sample;
        in_valid <= 1'b1;
        in_busy  = 1'b1;
        in_gap   = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stalls on out_ready.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_hold = pick_gap(out_calm);
    end
  end

  // Rising-edge sampling: predict on each accepted input word, check each
  // accepted output word against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    lit_digit_t want;
    if (!rst) begin
      cycles++;
      if (in_valid && in_ready) begin
        digit_queue.push_back(scan_tick(tracked_state, held_sample));
        in_busy = 1'b0;
      end
      if (out_valid && out_ready) begin
        if (digit_queue.size() == 0) begin
          report("output word with nothing expected", digit_value, 0);
        end else begin
          want = digit_queue.pop_front();
          words_checked++;
          if (digit_enable !== want.digit_enable)
            report("digit_enable", digit_enable, want.digit_enable);
          if (segments_n !== want.segments_n)
            report("segments_n", segments_n, want.segments_n);
          if (digit_value !== want.digit_value)
            report("digit_value", digit_value, want.digit_value);
          if (pass_start !== want.pass_start)
            report("pass_start", pass_start, want.pass_start);
        end
      end
      // Switch between calm stretches and gappy stretches now and then.
      if ($urandom_range(0, 149) == 0) in_calm = ~in_calm;
      if ($urandom_range(0, 149) == 0) out_calm = ~out_calm;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words still expected",
                 cycles, digit_queue.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned r;
    int unsigned slot;
    int unsigned n_pass;
    logic [11:0] smp;
    lookahead_state = reset_state();
    tracked_state   = reset_state();

    // Reset slot length (5): a one-digit and a four-digit pass.
    open_pass(12'd8);
    open_pass(12'd4095);

    // One tick per slot: every digit-count boundary and both extremes.
    set_slot_ticks(8'd1);
    foreach (BOUNDARY_VALUES[i]) open_pass(BOUNDARY_VALUES[i]);

    // Zero slot length acts as one tick.
    set_slot_ticks(8'd0);
    open_pass(12'd7);
    open_pass(12'd305);
    add_filler(2);

    // Longest slot, then stop mid-slot and shrink the slot below the count.
    set_slot_ticks(8'd255);
    open_pass(12'd9);
    open_pass(12'd6);
    add_filler(40);
    set_slot_ticks(8'd2);
    open_pass(12'd1234);
    add_filler(1);

    // Random phases: mostly short slots so many passes fit, a few long ones.
    while (words_queued < WORD_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 10)      slot = 0;
      else if (r < 60) slot = $urandom_range(1, 4);
      else if (r < 85) slot = $urandom_range(5, 24);
      else             slot = $urandom_range(25, 60);
      if (slot <= 4)       n_pass = $urandom_range(4, 16);
      else if (slot <= 24) n_pass = $urandom_range(1, 3);
      else                 n_pass = 1;
      set_slot_ticks(8'(slot));
      repeat (n_pass) begin
        if (words_queued >= WORD_GOAL) break;
        // Pass openers: all digit counts, boundaries, or any 12-bit value.
        r = $urandom_range(0, 99);
        if (r < 15)      smp = 12'($urandom_range(0, 9));
        else if (r < 30) smp = 12'($urandom_range(10, 99));
        else if (r < 45) smp = 12'($urandom_range(100, 999));
        else if (r < 70) smp = 12'($urandom_range(1000, 4095));
        else if (r < 85) smp = BOUNDARY_VALUES[$urandom_range(0, 9)];
        else             smp = 12'($urandom);
        open_pass(smp);
      end
      add_filler($urandom_range(0, 2 * slot + 3));
    end

    while (sample_queue.size() != 0 || in_busy || digit_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d input words opening %0d scan passes, %0d output words checked",
             words_queued, passes_queued, words_checked);
    $display("slot_ticks written %0d times (0, 1, 2 and 255 among them), %0d cycles",
             slot_writes, cycles);
    if (errors == 0 && digit_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
